@@ hdl/iri_pkg.sv @@
// Package for the image rotation block: register indexes, request codes, sizes.
// No dependencies.
package iri_pkg;

    typedef enum logic [2:0] {
        REG_INTERP_MODE    = 3'd0,
        REG_THREE_CHANNELS = 3'd1,
        REG_SRC_WIDTH      = 3'd2,
        REG_SRC_HEIGHT     = 3'd3,
        REG_DST_WIDTH      = 3'd4,
        REG_DST_HEIGHT     = 3'd5,
        REG_COS            = 3'd6,
        REG_SIN            = 3'd7
    } reg_index_t;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_SAMPLE  = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam int CFG_DATA_W = 21;
    localparam int PIX_W      = 24;

    // Frame store side and coefficient fraction; internal widths are built on these.
    localparam int MAX_SRC_SIDE = 256;
    localparam int FRAC_BITS    = 16;

    // Coordinate sample passed from the mapper to the sampler.
    typedef struct packed {
        logic       bilinear;
        logic       color;
        logic       outside;
        logic [7:0] u;
        logic [7:0] v;
    } samp_ctl_t;

endpackage

@@ hdl/iri_bank.sv @@
// One bank of the frame store: synchronous RAM, one write and one read port.
// Depends on nothing.
module iri_bank #(
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);
    logic [23:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/iri_blend.sv @@
// Bilinear blend of one 8-bit channel over four neighbors, registered products.
// Depends on nothing.
module iri_blend (
    input  logic       clk,
    input  logic [7:0] u,
    input  logic [7:0] v,
    input  logic [7:0] p00,
    input  logic [7:0] p01,
    input  logic [7:0] p10,
    input  logic [7:0] p11,
    output logic [7:0] q
);
    logic [8:0]  nu, nv;
    logic [17:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic [8:0]  nv_reg;
    logic [7:0]  v_reg;
    logic [25:0] acc;

    assign nu = 9'd256 - {1'b0, u};
    assign nv = 9'd256 - {1'b0, v};

    // horizontal stage then vertical
    always_ff @(posedge clk)
    begin
        a0_reg <= 18'(nu * p00);
        a1_reg <= 18'(u * p01);
        a2_reg <= 18'(nu * p10);
        a3_reg <= 18'(u * p11);
        nv_reg <= nv;
        v_reg  <= v;
    end

    assign acc = 26'(nv_reg * (a0_reg + a1_reg)) + 26'(v_reg * (a2_reg + a3_reg));
    assign q   = acc[23:16];
endmodule

@@ hdl/image_rotate_interpolation.sv @@
// Top level of the image rotation block: mapper, four-bank frame store, blend.
// Depends on iri_pkg, iri_bank, iri_blend.
//
// One beat (load or request) is taken every clock; busy is never raised. A load
// writes one pixel into the frame store (four banks split by row/column parity,
// so the 2x2 neighbors come out in one read). A request passes through map
// multiply, map sum and coordinate, bank read and blend to a registered result.
// The strobe done marks the result for one cycle; the receiver cannot stall,
// so results leave in request order at up to one per clock. Loads produce no
// result. Frame store contents are undefined until written.
module image_rotate_interpolation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data,
    input  logic        req_type,
    input  logic [7:0]  load_row,
    input  logic [7:0]  load_col,
    input  logic [23:0] load_pixel,
    input  logic [9:0]  dest_row,
    input  logic [9:0]  dest_col,
    output logic        done,
    output logic [23:0] out_pixel,
    output logic        outside
);
    localparam int MAX_SRC_SIDE = iri_pkg::MAX_SRC_SIDE;
    localparam int FRAC_BITS    = iri_pkg::FRAC_BITS;
    localparam int SB = $clog2(MAX_SRC_SIDE);      // address bits per side
    localparam int HB = SB - 1;                    // per-bank bits per side
    localparam int CW = FRAC_BITS + 5;             // coefficient width
    localparam int PW = CW + 12;                   // product width
    localparam int XW = PW + 3;                    // coordinate sum width

    // configuration
    logic             mode_reg, color_reg;
    logic [8:0]       sw_cfg_reg, sh_cfg_reg;
    logic [10:0]      dw_reg, dh_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            color_reg  <= 1'b0;
            sw_cfg_reg <= 9'd256;
            sh_cfg_reg <= 9'd256;
            dw_reg     <= 11'd256;
            dh_reg     <= 11'd256;
            cos_reg    <= CW'(1 << FRAC_BITS);
            sin_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (iri_pkg::reg_index_t'(cfg_index))
                iri_pkg::REG_INTERP_MODE:    mode_reg   <= cfg_data[0];
                iri_pkg::REG_THREE_CHANNELS: color_reg  <= cfg_data[0];
                iri_pkg::REG_SRC_WIDTH:      sw_cfg_reg <= cfg_data[8:0];
                iri_pkg::REG_SRC_HEIGHT:     sh_cfg_reg <= cfg_data[8:0];
                iri_pkg::REG_DST_WIDTH:      dw_reg     <= cfg_data[10:0];
                iri_pkg::REG_DST_HEIGHT:     dh_reg     <= cfg_data[10:0];
                iri_pkg::REG_COS:            cos_reg    <= CW'(signed'(cfg_data));
                iri_pkg::REG_SIN:            sin_reg    <= CW'(signed'(cfg_data));
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // effective source size, saturated
    logic [SB:0] sw_eff, sh_eff;
    assign sw_eff = (sw_cfg_reg > 9'(MAX_SRC_SIDE)) ? (SB+1)'(MAX_SRC_SIDE)
                                                    : (SB+1)'(sw_cfg_reg);
    assign sh_eff = (sh_cfg_reg > 9'(MAX_SRC_SIDE)) ? (SB+1)'(MAX_SRC_SIDE)
                                                    : (SB+1)'(sh_cfg_reg);

    // ---- stage 1: the four products
    logic signed [11:0] dx2, dy2;
    assign dy2 = $signed({1'b0, dest_row, 1'b0}) - $signed({1'b0, dh_reg});
    assign dx2 = $signed({1'b0, dest_col, 1'b0}) - $signed({1'b0, dw_reg});

    logic              s1_vld_reg;
    logic signed [PW-1:0] p_ys_reg, p_xc_reg, p_yc_reg, p_xs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && (req_type == iri_pkg::REQ_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        p_ys_reg <= PW'(dy2 * sin_reg);
        p_xc_reg <= PW'(dx2 * cos_reg);
        p_yc_reg <= PW'(dy2 * cos_reg);
        p_xs_reg <= PW'(dx2 * sin_reg);
    end

    // ---- stage 2: sums, floor, bounds, bank addresses
    logic signed [XW-1:0] xh, yh, xr, yr, xs, ys;
    logic signed [XW-1:0] cx, ry;
    logic                 out_c;
    assign xh = XW'(signed'({1'b0, sw_eff}) <<< FRAC_BITS) + XW'(p_ys_reg) + XW'(p_xc_reg);
    assign yh = XW'(signed'({1'b0, sh_eff}) <<< FRAC_BITS) + XW'(p_yc_reg) - XW'(p_xs_reg);
    assign xr = xh + XW'(1 << FRAC_BITS);
    assign yr = yh + XW'(1 << FRAC_BITS);
    assign xs = (mode_reg == iri_pkg::MODE_BILINEAR) ? xh : xr;
    assign ys = (mode_reg == iri_pkg::MODE_BILINEAR) ? yh : yr;
    assign cx = xs >>> (FRAC_BITS + 1);
    assign ry = ys >>> (FRAC_BITS + 1);

    logic signed [XW-1:0] xlim, ylim;
    assign xlim = (mode_reg == iri_pkg::MODE_BILINEAR) ? XW'(signed'({1'b0, sw_eff})) - 1
                                                       : XW'(signed'({1'b0, sw_eff}));
    assign ylim = (mode_reg == iri_pkg::MODE_BILINEAR) ? XW'(signed'({1'b0, sh_eff})) - 1
                                                       : XW'(signed'({1'b0, sh_eff}));
    assign out_c = (cx < 0) || (cx >= xlim) || (ry < 0) || (ry >= ylim);

    // neighbor coordinates (only meaningful when inside)
    logic [SB-1:0] c0, r0, c1, r1;
    assign c0 = cx[SB-1:0];
    assign r0 = ry[SB-1:0];
    assign c1 = c0 + SB'(1);
    assign r1 = r0 + SB'(1);

    // Bank b = {row parity, col parity}. For each bank pick the row/col of the
    // neighbor that lands there.
    logic [HB-1:0] rowsel [2];
    logic [HB-1:0] colsel [2];
    always_comb
    begin
        rowsel[0] = r0[0] ? r1[SB-1:1] : r0[SB-1:1];
        rowsel[1] = r0[0] ? r0[SB-1:1] : r1[SB-1:1];
        colsel[0] = c0[0] ? c1[SB-1:1] : c0[SB-1:1];
        colsel[1] = c0[0] ? c0[SB-1:1] : c1[SB-1:1];
    end

    logic [2*HB-1:0] raddr [4];
    logic            bank_we [4];
    logic [2*HB-1:0] waddr;
    logic            load_ok;
    assign load_ok = start && (req_type == iri_pkg::REQ_LOAD)
                     && ({1'b0, load_row} < 9'(MAX_SRC_SIDE))
                     && ({1'b0, load_col} < 9'(MAX_SRC_SIDE));
    assign waddr = {load_row[SB-1:1], load_col[SB-1:1]};

    logic [23:0] rdata [4];
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_bank
            assign raddr[g]   = {rowsel[g/2], colsel[g%2]};
            assign bank_we[g] = load_ok && (load_row[0] == 1'(g/2))
                                        && (load_col[0] == 1'(g%2));
            iri_bank #(.AW(2*HB)) u_bank (
                .clk   (clk),
                .we    (bank_we[g]),
                .waddr (waddr),
                .wdata (load_pixel),
                .raddr (raddr[g]),
                .rdata (rdata[g])
            );
        end
    endgenerate

    // ---- stage 3: read data arrives; carry control
    logic                 s3_vld_reg, s4_vld_reg;
    iri_pkg::samp_ctl_t   s3_ctl_reg, s4_ctl_reg;
    logic [1:0]           s3_par_reg;
    iri_pkg::samp_ctl_t   s2_ctl;
    assign s2_ctl.bilinear = mode_reg;
    assign s2_ctl.color    = color_reg;
    assign s2_ctl.outside  = out_c;
    assign s2_ctl.u        = xh[FRAC_BITS:FRAC_BITS-7];
    assign s2_ctl.v        = yh[FRAC_BITS:FRAC_BITS-7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s1_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            done       <= s4_vld_reg;
        end
    end

    logic [23:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [23:0] p00, p01, p10, p11;
    always_ff @(posedge clk)
    begin
        s3_ctl_reg <= s2_ctl;
        s3_par_reg <= {r0[0], c0[0]};
        s4_ctl_reg <= s3_ctl_reg;
        p00_reg    <= p00;
        p01_reg    <= p01;
        p10_reg    <= p10;
        p11_reg    <= p11;
    end

    // undo bank swizzle
    assign p00 = rdata[{s3_par_reg[1],  s3_par_reg[0]}];
    assign p01 = rdata[{s3_par_reg[1], ~s3_par_reg[0]}];
    assign p10 = rdata[{~s3_par_reg[1], s3_par_reg[0]}];
    assign p11 = rdata[{~s3_par_reg[1], ~s3_par_reg[0]}];

    // blend: first stage registered inside from stage-3 data
    logic [7:0] q [3];
    generate
        for (g = 0; g < 3; g++)
        begin : g_ch
            iri_blend u_blend (
                .clk (clk),
                .u   (s3_ctl_reg.u),
                .v   (s3_ctl_reg.v),
                .p00 (p00[8*g +: 8]),
                .p01 (p01[8*g +: 8]),
                .p10 (p10[8*g +: 8]),
                .p11 (p11[8*g +: 8]),
                .q   (q[g])
            );
        end
    endgenerate

    logic [23:0] pix;
    always_comb
    begin
        if (s4_ctl_reg.outside)
        begin
            pix = '0;
        end
        else if (s4_ctl_reg.bilinear)
        begin
            pix = {q[2], q[1], q[0]};
        end
        else
        begin
            pix = p00_reg;
        end
        if (!s4_ctl_reg.color)
        begin
            pix[23:8] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel <= pix;
        outside   <= s4_ctl_reg.outside;
    end

    // ---- checks
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && outside |-> out_pixel == 24'd0)
        else $error("outside result not black");
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(s4_ctl_reg.color) |-> out_pixel[23:8] == 16'd0)
        else $error("grey result has upper bytes");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        start && req_type == iri_pkg::REQ_SAMPLE |-> ##4 done)
        else $error("request lost in pipeline");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        start && req_type == iri_pkg::REQ_LOAD |=> !s1_vld_reg)
        else $error("load made a result");
endmodule

@@ dv/tb.sv @@
// Testbench for image_rotate_interpolation: directed and random load/request beats,
// config phases between drains, self-checking against an in-bench inverse-mapping predictor.
// Depends on iri_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One input beat as queued for the driver.
    typedef struct {
        logic        kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [23:0] pix;
        logic [9:0]  drow;
        logic [9:0]  dcol;
    } beat_t;

    // One expected destination pixel.
    typedef struct {
        logic [23:0] pix;
        logic        outside;
    } dest_pix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;
    logic        req_type = iri_pkg::REQ_LOAD;
    logic [7:0]  load_row = '0;
    logic [7:0]  load_col = '0;
    logic [23:0] load_pixel = '0;
    logic [9:0]  dest_row = '0;
    logic [9:0]  dest_col = '0;
    logic        done;
    logic [23:0] out_pixel;
    logic        outside;

    image_rotate_interpolation dut (.*);

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the block's registers; written only while the block is idle.
    logic               mode_q = iri_pkg::MODE_NEAREST;
    logic               color_q = 1'b0;
    logic [8:0]         sw_q = 9'd256;
    logic [8:0]         sh_q = 9'd256;
    logic [10:0]        dw_q = 11'd256;
    logic [10:0]        dh_q = 11'd256;
    logic signed [20:0] cos_q = 21'sd65536;
    logic signed [20:0] sin_q = 21'sd0;

    // Predictor's copy of the frame store, and the generator's record of
    // which entries have been loaded (so no request reads an unwritten one).
    logic [23:0] src_pix [65536];
    bit          loaded [65536];

    beat_t     pend_q[$];
    dest_pix_t exp_q[$];
    int        errors = 0;
    int        n_loads = 0, n_reqs = 0, n_out = 0, n_bilin = 0;

    // Inverse map of one destination pixel: base row/col, weights, outside flag.
    function automatic void map_dest(input logic [9:0] i, input logic [9:0] j,
                                     output bit off, output int ry, output int cx,
                                     output logic [7:0] u, output logic [7:0] v);
        longint sw, sh, xh, yh, c, s, dy2, dx2, rl, cl;
        sw = (sw_q > 9'd256) ? 256 : longint'(sw_q);
        sh = (sh_q > 9'd256) ? 256 : longint'(sh_q);
        c = cos_q;
        s = sin_q;
        dy2 = 2 * longint'(i) - longint'(dh_q);
        dx2 = 2 * longint'(j) - longint'(dw_q);
        xh = sw * 65536 + dy2 * s + dx2 * c;
        yh = sh * 65536 + dy2 * c - dx2 * s;
        u = xh[16:9];
        v = yh[16:9];
        if (mode_q == iri_pkg::MODE_NEAREST) begin
            cl = (xh + 65536) >>> 17;
            rl = (yh + 65536) >>> 17;
            off = cl < 0 || cl >= sw || rl < 0 || rl >= sh;
        end
        else begin
            cl = xh >>> 17;
            rl = yh >>> 17;
            off = cl < 0 || cl >= sw - 1 || rl < 0 || rl >= sh - 1;
        end
        cx = off ? 0 : int'(cl);
        ry = off ? 0 : int'(rl);
    endfunction

    function automatic dest_pix_t predict_pixel(input logic [9:0] i, input logic [9:0] j);
        dest_pix_t  r;
        bit         off;
        int         ry, cx, acc, nch;
        logic [7:0] u, v;
        logic [23:0] p00, p01, p10, p11;
        map_dest(i, j, off, ry, cx, u, v);
        r.pix = '0;
        r.outside = off;
        if (!off) begin
            p00 = src_pix[ry * 256 + cx];
            if (mode_q == iri_pkg::MODE_NEAREST) begin
                r.pix = color_q ? p00 : {16'h0, p00[7:0]};
            end
            else begin
                p01 = src_pix[ry * 256 + cx + 1];
                p10 = src_pix[(ry + 1) * 256 + cx];
                p11 = src_pix[(ry + 1) * 256 + cx + 1];
                nch = color_q ? 3 : 1;
                for (int k = 0; k < nch; k++) begin
                    acc = (256 - u) * (256 - v) * p00[8*k +: 8]
                        + u * (256 - v) * p01[8*k +: 8]
                        + (256 - u) * v * p10[8*k +: 8]
                        + u * v * p11[8*k +: 8];
                    r.pix[8*k +: 8] = acc[23:16];
                end
            end
        end
        return r;
    endfunction

    function automatic void queue_load(input int r, input int c, input logic [23:0] p);
        beat_t b;
        b.kind = iri_pkg::REQ_LOAD;
        b.row = r[7:0];
        b.col = c[7:0];
        b.pix = p;
        b.drow = 10'($urandom);
        b.dcol = 10'($urandom);
        loaded[r * 256 + c] = 1'b1;
        pend_q.push_back(b);
    endfunction

    // Queue a request, first loading any source pixel it reads that is still unknown.
    function automatic void queue_request(input logic [9:0] i, input logic [9:0] j);
        beat_t      b;
        bit         off;
        int         ry, cx;
        logic [7:0] u, v;
        map_dest(i, j, off, ry, cx, u, v);
        if (!off) begin
            for (int dr = 0; dr < 2; dr++)
                for (int dc = 0; dc < 2; dc++)
                    if ((dr == 0 && dc == 0) || mode_q == iri_pkg::MODE_BILINEAR)
                        if (!loaded[(ry + dr) * 256 + cx + dc])
                            queue_load(ry + dr, cx + dc, 24'($urandom));
        end
        b.kind = iri_pkg::REQ_SAMPLE;
        b.row = 8'($urandom);
        b.col = 8'($urandom);
        b.pix = 24'($urandom);
        b.drow = i;
        b.dcol = j;
        pend_q.push_back(b);
    endfunction

    task automatic write_reg(input iri_pkg::reg_index_t idx, input logic [20:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            iri_pkg::REG_INTERP_MODE:    mode_q = val[0];
            iri_pkg::REG_THREE_CHANNELS: color_q = val[0];
            iri_pkg::REG_SRC_WIDTH:      sw_q = val[8:0];
            iri_pkg::REG_SRC_HEIGHT:     sh_q = val[8:0];
            iri_pkg::REG_DST_WIDTH:      dw_q = val[10:0];
            iri_pkg::REG_DST_HEIGHT:     dh_q = val[10:0];
            iri_pkg::REG_COS:            cos_q = val;
            iri_pkg::REG_SIN:            sin_q = val;
            default: ;
        endcase
    endtask

    // Wait until every queued beat is taken and every result has come back,
    // then let the pipeline empty out.
    task automatic drain();
        while (pend_q.size() != 0 || start || exp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Driver: beats change at the falling edge, in bursts with random gaps.
    bit taken = 1'b0;
    int burst_left = 0, gap_left = 0;
    always @(negedge clk) begin
        beat_t b;
        if (rst_n && (!start || taken)) begin
            taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pend_q.size() != 0) begin
                b = pend_q.pop_front();
                start <= 1'b1;
                req_type <= b.kind;
                load_row <= b.row;
                load_col <= b.col;
                load_pixel <= b.pix;
                dest_row <= b.drow;
                dest_col <= b.dcol;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: take accepted beats into the predictor, check each result strobe.
    always @(posedge clk) begin
        dest_pix_t e;
        if (rst_n) begin
            if (start && !busy) begin
                taken = 1'b1;
                if (req_type == iri_pkg::REQ_LOAD) begin
                    src_pix[load_row * 256 + load_col] = load_pixel;
                    n_loads++;
                end
                else begin
                    exp_q.push_back(predict_pixel(dest_row, dest_col));
                    n_reqs++;
                    if (mode_q == iri_pkg::MODE_BILINEAR)
                        n_bilin++;
                end
            end
            if (done) begin
                if (exp_q.size() == 0) begin
                    $error("result with no request pending: pixel %h outside %b",
                           out_pixel, outside);
                    errors++;
                end
                else begin
                    e = exp_q.pop_front();
                    if (outside) n_out++;
                    if (out_pixel !== e.pix) begin
                        $error("out_pixel: expected %h, got %h", e.pix, out_pixel);
                        errors++;
                    end
                    if (outside !== e.outside) begin
                        $error("outside: expected %b, got %b", e.outside, outside);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [10:0] ci, cj;
        int          cnt;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings (nearest, grey, 256x256, identity map).
        queue_load(0, 0, 24'hFFFFFF);
        queue_load(255, 255, 24'h000000);
        queue_load(0, 255, 24'hA5A5A5);
        queue_load(255, 0, 24'h5A5A5A);
        queue_request(10'd128, 10'd128);
        queue_request(10'd0, 10'd0);
        queue_request(10'd255, 10'd255);
        queue_request(10'd0, 10'd255);
        queue_request(10'd1023, 10'd1023);
        queue_request(10'd256, 10'd0);
        drain();

        for (int p = 0; p < 12; p++) begin
            write_reg(iri_pkg::REG_INTERP_MODE, 21'(p % 2));
            write_reg(iri_pkg::REG_THREE_CHANNELS, 21'((p / 2) % 2));
            case (p)
                2:       begin
                    write_reg(iri_pkg::REG_SRC_WIDTH, 21'd1);
                    write_reg(iri_pkg::REG_SRC_HEIGHT, 21'd1);
                end
                3:       begin
                    write_reg(iri_pkg::REG_SRC_WIDTH, 21'd0);
                    write_reg(iri_pkg::REG_SRC_HEIGHT, 21'd9);
                end
                4:       begin
                    write_reg(iri_pkg::REG_SRC_WIDTH, 21'd511);
                    write_reg(iri_pkg::REG_SRC_HEIGHT, 21'd300);
                end
                5:       begin
                    write_reg(iri_pkg::REG_SRC_WIDTH, 21'd256);
                    write_reg(iri_pkg::REG_SRC_HEIGHT, 21'd256);
                end
                default: begin
                    write_reg(iri_pkg::REG_SRC_WIDTH, 21'($urandom_range(2, 24)));
                    write_reg(iri_pkg::REG_SRC_HEIGHT, 21'($urandom_range(2, 24)));
                end
            endcase
            case (p)
                6:       begin
                    write_reg(iri_pkg::REG_DST_WIDTH, 21'd0);
                    write_reg(iri_pkg::REG_DST_HEIGHT, 21'd0);
                end
                7:       begin
                    write_reg(iri_pkg::REG_DST_WIDTH, 21'd2047);
                    write_reg(iri_pkg::REG_DST_HEIGHT, 21'd2047);
                end
                10:      begin
                    write_reg(iri_pkg::REG_DST_WIDTH, 21'd1024);
                    write_reg(iri_pkg::REG_DST_HEIGHT, 21'd1);
                end
                default: begin
                    write_reg(iri_pkg::REG_DST_WIDTH, 21'($urandom_range(1, 64)));
                    write_reg(iri_pkg::REG_DST_HEIGHT, 21'($urandom_range(1, 64)));
                end
            endcase
            case (p)
                8:       begin
                    write_reg(iri_pkg::REG_COS, 21'h100000);
                    write_reg(iri_pkg::REG_SIN, 21'h0FFFFF);
                end
                9:       begin
                    write_reg(iri_pkg::REG_COS, 21'h0FFFFF);
                    write_reg(iri_pkg::REG_SIN, 21'h100000);
                end
                default: begin
                    // rotation with random zoom, each coefficient between -95000 and 95000 (about +/-1.45)
                    write_reg(iri_pkg::REG_COS,
                              21'($signed($urandom_range(0, 190000)) - 95000));
                    write_reg(iri_pkg::REG_SIN,
                              21'($signed($urandom_range(0, 190000)) - 95000));
                end
            endcase
            @(negedge clk);
            cfg_we <= 1'b0;

            cnt = 0;
            while (cnt < 112) begin
                if ($urandom_range(0, 3) == 0)
                    queue_load($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
                else if ($urandom_range(0, 4) == 0)
                    queue_request(10'($urandom), 10'($urandom));
                else begin
                    // near the destination center, where most points land inside
                    ci = 11'(dh_q / 2 + $urandom_range(0, 40) - 20);
                    cj = 11'(dw_q / 2 + $urandom_range(0, 40) - 20);
                    queue_request(ci[9:0], cj[9:0]);
                end
                cnt++;
            end
            drain();
        end

        $display("covered %0d loads and %0d requests (%0d bilinear), %0d results outside",
                 n_loads, n_reqs, n_bilin, n_out);
        $display("across 13 register settings incl. degenerate and saturating sizes");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/iri_pkg.sv
hdl/iri_bank.sv
hdl/iri_blend.sv
hdl/image_rotate_interpolation.sv
dv/tb.sv
